// ----- design/port_scan_detector_assert.svh -----
// Assertion macros used by the port scan detector datapath.
`ifndef PORT_SCAN_DETECTOR_ASSERT_SVH
`define PORT_SCAN_DETECTOR_ASSERT_SVH

// Condition that holds at every active clock edge.
`define PSD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication into the next cycle.
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/psd_pkg.sv -----
// Package: shared types and constants of the port scan detector.
`timescale 1ns / 1ps
package psd_pkg;

  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
  localparam logic [16:0] ETH_TCP_BYTES = 17'd34;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [3:0]  IP_V4         = 4'd4;

  localparam logic [0:0]  RST_ENABLE    = 1'b0;
  localparam logic [3:0]  RST_THRESHOLD = 4'd5;
  localparam logic [15:0] RST_WINDOW    = 16'd60;
  localparam logic [7:0]  RST_INTERVAL  = 8'd10;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_WINDOW    = 2'd2,
    CFG_INTERVAL  = 2'd3
  } psd_cfg_idx_t;

  typedef enum logic [2:0] {
    STAT_COUNTED  = 3'd0,
    STAT_DISABLED = 3'd1,
    STAT_SHORT    = 3'd2,
    STAT_NOT_IPV4 = 3'd3,
    STAT_FULL     = 3'd4
  } psd_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH,
    S_UPD,
    S_PORT,
    S_WRITE,
    S_EMIT
  } psd_state_t;

  typedef struct packed {
    logic capture;
    logic classify;
    logic srch_init;
    logic srch_step;
    logic mark_full;
    logic alloc;
    logic update;
    logic port_step;
    logic commit;
    logic emit;
  } psd_cmd_t;

  typedef struct packed {
    logic reject;
    logic srch_hit;
    logic srch_miss;
    logic table_full;
    logic tcp_ok;
    logic port_done;
    logic out_free;
  } psd_stat_t;

endpackage

// ----- design/psd_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module psd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/psd_ctrl.sv -----
// Controller: sequences classify, source search, port search, write-back and result emit.
`timescale 1ns / 1ps
module psd_ctrl
  import psd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  psd_stat_t stat,
  output psd_cmd_t  cmd
);

  psd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.classify = 1'b1;
        if (stat.reject) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (stat.srch_hit) begin
          state_nxt = S_UPD;
        end else if (stat.srch_miss) begin
          if (stat.table_full) begin
            cmd.mark_full = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cmd.alloc = 1'b1;
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = stat.tcp_ok ? S_PORT : S_WRITE;
      end
      S_PORT: begin
        cmd.port_step = 1'b1;
        if (stat.port_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/psd_datapath.sv -----
// Datapath: config registers, source table, port store and result register.
`timescale 1ns / 1ps
`include "port_scan_detector_assert.svh"
module psd_datapath
  import psd_pkg::*;
#(
  parameter int MAX_SOURCES = 64,
  parameter int MAX_PORTS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [15:0] in_frame_length,
  input  logic [3:0]  in_ip_version,
  input  logic [3:0]  in_header_words,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_destination_port,
  input  logic [31:0] in_arrival_second,
  input  psd_cmd_t    cmd,
  output psd_stat_t   stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_scanner_flag,
  output logic        out_report_request,
  output logic        out_deploy_request,
  output logic [4:0]  out_distinct_ports,
  output logic [31:0] out_packet_total,
  output logic [31:0] out_reported_address
);

  localparam int AW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW  = $clog2(MAX_SOURCES + 1);
  localparam int PCW = $clog2(MAX_PORTS + 1);
  localparam int PD  = MAX_SOURCES * MAX_PORTS;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;

  typedef struct packed {
    logic [31:0]    addr;
    logic [31:0]    first;
    logic [31:0]    pkts;
    logic [7:0]     phase;
    logic [PCW-1:0] cnt;
  } entry_t;

  // configuration
  logic        enable_r;
  logic [3:0]  thr_r;
  logic [15:0] win_r;
  logic [7:0]  ivl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= RST_ENABLE;
      thr_r    <= RST_THRESHOLD;
      win_r    <= RST_WINDOW;
      ivl_r    <= RST_INTERVAL;
    end else if (cfg_wr_en) begin
      case (psd_cfg_idx_t'(cfg_index))
        CFG_ENABLE:    enable_r <= cfg_data[0];
        CFG_THRESHOLD: thr_r    <= cfg_data[3:0];
        CFG_WINDOW:    win_r    <= cfg_data;
        CFG_INTERVAL:  ivl_r    <= cfg_data[7:0];
        default:       ;
      endcase
    end
  end

  // captured item
  logic [15:0] flen_r;
  logic [3:0]  ver_r;
  logic [3:0]  hw_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [15:0] dport_r;
  logic [31:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      flen_r  <= in_frame_length;
      ver_r   <= in_ip_version;
      hw_r    <= in_header_words;
      proto_r <= in_ip_protocol;
      src_r   <= in_source_address;
      dport_r <= in_destination_port;
      now_r   <= in_arrival_second;
    end
  end

  psd_status_t class_code;
  always_comb begin
    if (!enable_r) begin
      class_code = STAT_DISABLED;
    end else if (flen_r < ETH_HDR_BYTES) begin
      class_code = STAT_SHORT;
    end else if (ver_r != IP_V4) begin
      class_code = STAT_NOT_IPV4;
    end else begin
      class_code = STAT_COUNTED;
    end
  end

  // control and working registers
  psd_status_t    code_r;
  logic [CW-1:0]  fill_r;
  logic [CW-1:0]  idx_r;
  logic [AW-1:0]  pend_idx_r;
  logic           pend_r;
  logic [AW-1:0]  slot_r;
  logic           new_r;
  logic           rep_r;
  logic [PCW-1:0] kidx_r;
  logic           ppend_r;
  entry_t         ent_r;
  logic           out_valid_r;

  entry_t         ent_rd;
  logic [15:0]    port_rd;

  logic           issue;
  logic           hit;
  logic           pissue;
  logic           seen;
  logic           pdone;
  logic           append;
  logic [PAW-1:0] base;
  logic [PAW-1:0] p_raddr;
  logic [PAW-1:0] p_waddr;
  logic [16:0]    len_need;
  logic [8:0]     phase_inc;
  logic [7:0]     ivl_eff;
  logic [31:0]    elapsed;
  logic           flag;

  assign issue    = idx_r < fill_r;
  assign hit      = pend_r && (ent_rd.addr == src_r);
  assign pissue   = kidx_r < ent_r.cnt;
  assign seen     = ppend_r && (port_rd == dport_r);
  assign pdone    = seen || (!ppend_r && !pissue);
  assign append   = cmd.port_step && pdone && !seen && (ent_r.cnt < PCW'(MAX_PORTS));
  assign base     = PAW'(slot_r) * PAW'(MAX_PORTS);
  assign p_raddr  = base + PAW'(kidx_r);
  assign p_waddr  = base + PAW'(ent_r.cnt);
  assign len_need = ETH_TCP_BYTES + {11'b0, hw_r, 2'b00};
  assign phase_inc = {1'b0, ent_r.phase} + 9'd1;
  assign ivl_eff  = (ivl_r == 8'd0) ? 8'd1 : ivl_r;
  assign elapsed  = (now_r >= ent_r.first) ? (now_r - ent_r.first) : 32'd0;
  assign flag     = (9'(ent_r.cnt) > 9'(thr_r)) && (elapsed < {16'b0, win_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r      <= STAT_DISABLED;
      fill_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      ppend_r     <= 1'b0;
      kidx_r      <= '0;
      new_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.classify) begin
        code_r <= class_code;
      end
      if (cmd.mark_full) begin
        code_r <= STAT_FULL;
      end
      if (cmd.srch_init) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
        new_r  <= 1'b0;
      end
      if (cmd.srch_step) begin
        if (hit) begin
          pend_r <= 1'b0;
        end else begin
          pend_r <= issue;
          if (issue) begin
            idx_r <= idx_r + CW'(1);
          end
        end
      end
      if (cmd.alloc) begin
        new_r <= 1'b1;
      end
      if (cmd.update) begin
        kidx_r  <= '0;
        ppend_r <= 1'b0;
      end
      if (cmd.port_step) begin
        if (pdone) begin
          ppend_r <= 1'b0;
        end else begin
          ppend_r <= pissue;
          if (pissue) begin
            kidx_r <= kidx_r + PCW'(1);
          end
        end
      end
      if (cmd.commit && new_r) begin
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_step && !hit && issue) begin
      pend_idx_r <= idx_r[AW-1:0];
    end
    if (cmd.srch_step && hit) begin
      slot_r <= pend_idx_r;
      ent_r  <= ent_rd;
    end
    if (cmd.alloc) begin
      slot_r      <= fill_r[AW-1:0];
      ent_r.addr  <= src_r;
      ent_r.first <= now_r;
      ent_r.pkts  <= '0;
      ent_r.phase <= '0;
      ent_r.cnt   <= '0;
    end
    if (cmd.update) begin
      if (ent_r.pkts != 32'hFFFF_FFFF) begin
        ent_r.pkts <= ent_r.pkts + 32'd1;
      end
      if (phase_inc >= {1'b0, ivl_eff}) begin
        ent_r.phase <= '0;
        rep_r       <= 1'b1;
      end else begin
        ent_r.phase <= phase_inc[7:0];
        rep_r       <= 1'b0;
      end
    end
    if (append) begin
      ent_r.cnt <= ent_r.cnt + PCW'(1);
    end
  end

  psd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_SOURCES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (slot_r),
    .wdata (ent_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (ent_rd)
  );

  psd_ram #(
    .WIDTH (16),
    .DEPTH (PD)
  ) u_port_ram (
    .clk   (clk),
    .we    (append),
    .waddr (p_waddr),
    .wdata (dport_r),
    .raddr (p_raddr),
    .rdata (port_rd)
  );

  // result register
  logic [2:0]  st_q;
  logic        flag_q;
  logic        rep_q;
  logic [4:0]  ports_q;
  logic [31:0] total_q;
  logic [31:0] addr_q;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      st_q <= code_r;
      if (code_r == STAT_COUNTED) begin
        flag_q  <= flag;
        rep_q   <= flag && rep_r;
        ports_q <= 5'(ent_r.cnt);
        total_q <= ent_r.pkts;
        addr_q  <= src_r;
      end else begin
        flag_q  <= 1'b0;
        rep_q   <= 1'b0;
        ports_q <= '0;
        total_q <= '0;
        addr_q  <= (code_r == STAT_FULL) ? src_r : 32'd0;
      end
    end
  end

  assign stat.reject     = (class_code != STAT_COUNTED);
  assign stat.srch_hit   = hit;
  assign stat.srch_miss  = !pend_r && !issue;
  assign stat.table_full = (fill_r == CW'(MAX_SOURCES));
  assign stat.tcp_ok     = (proto_r == PROTO_TCP) && ({1'b0, flen_r} >= len_need);
  assign stat.port_done  = pdone;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_status           = st_q;
  assign out_scanner_flag     = flag_q;
  assign out_report_request   = rep_q;
  assign out_deploy_request   = flag_q;
  assign out_distinct_ports   = ports_q;
  assign out_packet_total     = total_q;
  assign out_reported_address = addr_q;

  `PSD_ASSERT_ALWAYS(a_fill_bound, fill_r <= CW'(MAX_SOURCES), "source fill count overflow")
  `PSD_ASSERT_ALWAYS(a_port_bound, !cmd.commit || (ent_r.cnt <= PCW'(MAX_PORTS)),
    "port count overflow")
  `PSD_ASSERT_NEXT(a_fill_inc, cmd.commit && new_r, fill_r == $past(fill_r) + CW'(1),
    "allocation did not advance fill count")
  `PSD_ASSERT_ALWAYS(a_reject_clean,
    !(out_valid_r && (st_q != STAT_COUNTED)) || (!flag_q && !rep_q && (total_q == 32'd0)),
    "uncounted item carries counters")

endmodule

// ----- design/port_scan_detector.sv -----
// Top level of the port scan detector.
// One item is handled at a time. The source search reads one table entry per
// cycle from the source RAM, over the sources already in the table (up to
// MAX_SOURCES); when the TCP check passes, the port search then reads one
// stored port per cycle from the port RAM, over the ports stored for that
// source (up to MAX_PORTS). Rejected items skip both searches. The result
// register lets the next item be accepted while the previous result still
// waits to be taken. No clearing pass after reset: the table fills in order,
// tracked by a fill count.
`timescale 1ns / 1ps
module port_scan_detector
  import psd_pkg::*;
#(
  parameter int MAX_SOURCES = 64,
  parameter int MAX_PORTS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_frame_length,
  input  logic [3:0]  in_ip_version,
  input  logic [3:0]  in_header_words,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_destination_port,
  input  logic [31:0] in_arrival_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_scanner_flag,
  output logic        out_report_request,
  output logic        out_deploy_request,
  output logic [4:0]  out_distinct_ports,
  output logic [31:0] out_packet_total,
  output logic [31:0] out_reported_address
);

  psd_cmd_t  cmd;
  psd_stat_t stat;

  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  psd_datapath #(
    .MAX_SOURCES (MAX_SOURCES),
    .MAX_PORTS   (MAX_PORTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_frame_length      (in_frame_length),
    .in_ip_version        (in_ip_version),
    .in_header_words      (in_header_words),
    .in_ip_protocol       (in_ip_protocol),
    .in_source_address    (in_source_address),
    .in_destination_port  (in_destination_port),
    .in_arrival_second    (in_arrival_second),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_scanner_flag     (out_scanner_flag),
    .out_report_request   (out_report_request),
    .out_deploy_request   (out_deploy_request),
    .out_distinct_ports   (out_distinct_ports),
    .out_packet_total     (out_packet_total),
    .out_reported_address (out_reported_address)
  );

endmodule
